/* hw/rtl/pva_pkg.sv */
// pva_pkg: types and constants shared by the voice allocator files
// no dependencies
`default_nettype none

package pva_pkg;

  localparam int unsigned MAX_VOICES = 16;
  localparam int unsigned VIDX_W     = 4;
  localparam int unsigned PITCH_W    = 7;
  localparam int unsigned HELD_W     = 8;
  localparam int unsigned AGE_W      = 8;

  localparam logic [HELD_W-1:0] NO_PITCH = 8'hFF;

  localparam logic OP_NOTE_ON  = 1'b0;
  localparam logic OP_NOTE_OFF = 1'b1;

  typedef logic [VIDX_W-1:0]     vidx_t;
  typedef logic [PITCH_W-1:0]    pitch_t;
  typedef logic [HELD_W-1:0]     held_t;
  typedef logic [AGE_W-1:0]      age_t;
  typedef logic [MAX_VOICES-1:0] vmask_t;

  typedef struct packed {
    logic   found;
    vidx_t  voice;
    logic   set_on;
    logic   set_off;
    logic   clear_age;
    vmask_t age_inc;
  } pva_decision_t;

endpackage

`default_nettype wire

/* hw/rtl/pva_select.sv */
// pva_select: voice choice for one event, pure combinational
// depends on pva_pkg; per-voice state arrives padded to MAX_VOICES entries
`default_nettype none

module pva_select import pva_pkg::*; #(
  parameter int unsigned VOICES = 16
) (
  input  wire logic          opcode,
  input  wire pitch_t        pitch,
  input  wire vidx_t         track,
  input  wire vmask_t        group_mask,
  input  wire logic          map_direct,
  input  wire vmask_t        alloc_mask,
  input  wire held_t         held_pitch [MAX_VOICES],
  input  wire age_t          age        [MAX_VOICES],
  input  wire vmask_t        sounding,
  output pva_decision_t      decision
);

  localparam int unsigned LEVELS = 4;

  vmask_t cand;
  vmask_t same_pitch;
  logic   in_range;

  logic   has_asp, has_isp, has_inact, has_off;
  vidx_t  asp, isp, inact, off_idx;
  vidx_t  pick;
  logic   pick_ok;
  age_t   sel_age;

  logic   node_ok  [LEVELS+1][MAX_VOICES];
  vidx_t  node_idx [LEVELS+1][MAX_VOICES];
  age_t   node_age [LEVELS+1][MAX_VOICES];

  always_comb begin
    in_range = {1'b0, track} < 5'(VOICES);
    for (int i = 0; i < MAX_VOICES; i++) begin
      cand[i]       = group_mask[i] & alloc_mask[i] & (i < VOICES);
      same_pitch[i] = held_pitch[i] == {1'b0, pitch};
    end
  end

  // oldest sounding candidate, ties to the lower index
  always_comb begin
    for (int i = 0; i < MAX_VOICES; i++) begin
      node_ok[0][i]  = cand[i] & sounding[i];
      node_idx[0][i] = VIDX_W'(i);
      node_age[0][i] = age[i];
    end
    for (int l = 1; l <= LEVELS; l++) begin
      for (int n = 0; n < MAX_VOICES; n++) begin
        node_ok[l][n]  = 1'b0;
        node_idx[l][n] = '0;
        node_age[l][n] = '0;
      end
      for (int n = 0; n < (MAX_VOICES >> l); n++) begin
        if (node_ok[l-1][2*n] &&
            (!node_ok[l-1][2*n+1] || node_age[l-1][2*n] >= node_age[l-1][2*n+1])) begin
          node_ok[l][n]  = node_ok[l-1][2*n];
          node_idx[l][n] = node_idx[l-1][2*n];
          node_age[l][n] = node_age[l-1][2*n];
        end else begin
          node_ok[l][n]  = node_ok[l-1][2*n+1];
          node_idx[l][n] = node_idx[l-1][2*n+1];
          node_age[l][n] = node_age[l-1][2*n+1];
        end
      end
    end
  end

  always_comb begin
    has_asp = 1'b0; has_isp = 1'b0; has_inact = 1'b0; has_off = 1'b0;
    asp = '0; isp = '0; inact = '0; off_idx = '0;
    for (int i = 0; i < MAX_VOICES; i++) begin
      if (cand[i] && sounding[i] && same_pitch[i]) begin
        has_asp = 1'b1;
        asp     = VIDX_W'(i);
      end
      if (cand[i] && !sounding[i] && same_pitch[i]) begin
        has_isp = 1'b1;
        isp     = VIDX_W'(i);
      end
      if (cand[i] && !sounding[i]) begin
        has_inact = 1'b1;
        inact     = VIDX_W'(i);
      end
    end
    for (int i = MAX_VOICES - 1; i >= 0; i--) begin
      if (cand[i] && sounding[i] && same_pitch[i]) begin
        has_off = 1'b1;
        off_idx = VIDX_W'(i);
      end
    end
  end

  always_comb begin
    pick_ok = 1'b1;
    if (has_asp) begin
      pick = asp;
    end else if (has_isp) begin
      pick = isp;
    end else if (has_inact) begin
      pick = inact;
    end else begin
      pick    = node_idx[LEVELS][0];
      pick_ok = node_ok[LEVELS][0];
    end
    sel_age = '0;
    for (int i = 0; i < MAX_VOICES; i++) begin
      if (VIDX_W'(i) == pick) begin
        sel_age = age[i];
      end
    end
  end

  always_comb begin
    decision = '0;
    if (!in_range) begin
      decision = '0;
    end else if (group_mask == '0) begin
      if (map_direct) begin
        decision.found   = 1'b1;
        decision.voice   = track;
        decision.set_on  = opcode == OP_NOTE_ON;
        decision.set_off = opcode == OP_NOTE_OFF;
      end
    end else if (opcode == OP_NOTE_OFF) begin
      if (has_off) begin
        decision.found   = 1'b1;
        decision.voice   = off_idx;
        decision.set_off = 1'b1;
      end
    end else if (pick_ok) begin
      decision.found     = 1'b1;
      decision.voice     = pick;
      decision.set_on    = 1'b1;
      decision.clear_age = 1'b1;
      for (int i = 0; i < MAX_VOICES; i++) begin
        decision.age_inc[i] = cand[i] && (VIDX_W'(i) != pick) && (age[i] <= sel_age);
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/poly_voice_allocator.sv */
// poly_voice_allocator: polyphonic voice allocation with oldest-voice steal
// depends on pva_pkg and pva_select
// one event per cycle sustained while the output is not stalled
// the event register feeds the voice choice, which updates voice state and result register together
// synchronous active-high reset: all voices silent, pitch none, age zero, mask all ones
`default_nettype none

module poly_voice_allocator import pva_pkg::*; #(
  parameter int unsigned VOICES = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_write,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic         opcode,
  input  wire logic [6:0]   pitch,
  input  wire logic [3:0]   track,
  input  wire logic [15:0]  group_mask,
  input  wire logic         map_direct,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [3:0]        voice,
  output logic              found
);

  vmask_t alloc_mask;

  logic   ev_valid;
  logic   ev_opcode;
  pitch_t ev_pitch;
  vidx_t  ev_track;
  vmask_t ev_group;
  logic   ev_direct;

  held_t  held_pitch [VOICES];
  age_t   age        [VOICES];
  logic   sounding   [VOICES];

  held_t  held_pad   [MAX_VOICES];
  age_t   age_pad    [MAX_VOICES];
  vmask_t sound_pad;

  pva_decision_t decision;
  logic          out_free;
  logic          advance;
  logic          in_take;

  assign out_free = !out_valid || !out_stall;
  assign advance  = ev_valid && out_free;
  assign in_stall = ev_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  for (genvar g = 0; g < MAX_VOICES; g++) begin : g_pad
    if (g < VOICES) begin : g_used
      assign held_pad[g]  = held_pitch[g];
      assign age_pad[g]   = age[g];
      assign sound_pad[g] = sounding[g];
    end else begin : g_unused
      assign held_pad[g]  = NO_PITCH;
      assign age_pad[g]   = '0;
      assign sound_pad[g] = 1'b0;
    end
  end

  pva_select #(.VOICES(VOICES)) u_select (
    .opcode       (ev_opcode),
    .pitch        (ev_pitch),
    .track        (ev_track),
    .group_mask   (ev_group),
    .map_direct   (ev_direct),
    .alloc_mask   (alloc_mask),
    .held_pitch   (held_pad),
    .age          (age_pad),
    .sounding     (sound_pad),
    .decision     (decision)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_mask <= '1;
    end else if (cfg_write) begin
      alloc_mask <= cfg_data;
    end
  end

  // event register
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (in_take) begin
      ev_valid <= 1'b1;
    end else if (advance) begin
      ev_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ev_opcode <= opcode;
      ev_pitch  <= pitch;
      ev_track  <= track;
      ev_group  <= group_mask;
      ev_direct <= map_direct;
    end
  end

  // voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        held_pitch[i] <= NO_PITCH;
        age[i]        <= '0;
        sounding[i]   <= 1'b0;
      end
    end else if (advance && decision.found) begin
      for (int i = 0; i < VOICES; i++) begin
        if (VIDX_W'(i) == decision.voice) begin
          if (decision.set_on) begin
            sounding[i]   <= 1'b1;
            held_pitch[i] <= {1'b0, ev_pitch};
          end
          if (decision.set_off) begin
            sounding[i] <= 1'b0;
          end
          if (decision.clear_age) begin
            age[i] <= '0;
          end
        end else if (decision.age_inc[i]) begin
          age[i] <= age[i] + AGE_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      voice <= decision.found ? decision.voice : '0;
      found <= decision.found;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pva_checker.sv */
// pva_checker: port-level checks for poly_voice_allocator, with its bind
// depends on poly_voice_allocator ports only
`default_nettype none

module pva_checker #(
  parameter int unsigned VOICES = 16
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [3:0]  voice,
  input wire logic        found
);

  // no voice reported without a find
  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> voice == 4'd0)
    else $error("result without voice carries nonzero voice");

  a_voice_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> {1'b0, voice} < 5'(VOICES))
    else $error("reported voice beyond configured voices");

  // a fresh result follows an input transfer through the event and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without matching input transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(voice) && $stable(found))
    else $error("stalled result changed");

endmodule

bind poly_voice_allocator pva_checker #(.VOICES(VOICES)) u_pva_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .voice     (voice),
  .found     (found)
);

`default_nettype wire

/* dv/tb.sv */
// tb: self-checking bench for poly_voice_allocator, voice choice on note-on and note-off
// depends on pva_pkg and the poly_voice_allocator rtl; a built-in voice model predicts each result
// clocked driver and monitor with random idling on both channels, mask register varied per phase
module tb;
  import pva_pkg::*;

  localparam int unsigned NVOICES    = MAX_VOICES;
  localparam int unsigned PIPE_DEPTH = 2;
  localparam int unsigned SEG_EVENTS = 255;

  typedef struct packed {
    logic   op;
    pitch_t pitch;
    vidx_t  track;
    vmask_t group;
    logic   direct;
  } note_event_t;

  typedef struct packed {
    vidx_t voice;
    logic  found;
  } voice_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  voice;
  logic        found;
  note_event_t on_bus = '0;

  note_event_t   pending_events[$];
  note_event_t   held_notes[$];
  voice_result_t expected_results[$];
  pitch_t        pitch_pool[8];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors = 0;

  // voice state as the block should hold it
  vmask_t alloc_mask;
  held_t  model_pitch[NVOICES];
  age_t   voice_age[NVOICES];
  logic   voice_on[NVOICES];

  always #5 clk = ~clk;

  poly_voice_allocator #(.VOICES(NVOICES)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (on_bus.op),
    .pitch        (on_bus.pitch),
    .track        (on_bus.track),
    .group_mask   (on_bus.group),
    .map_direct   (on_bus.direct),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .voice        (voice),
    .found        (found)
  );

  task automatic reset_voices();
    alloc_mask = '1;
    for (int v = 0; v < NVOICES; v++) begin
      model_pitch[v] = NO_PITCH;
      voice_age[v]   = '0;
      voice_on[v]    = 1'b0;
    end
  endtask

  function automatic voice_result_t allocate_voice(note_event_t ev);
    voice_result_t r;
    vmask_t cand;
    held_t  want_pitch;
    logic   has_same_on, has_same_off, has_free, has_old;
    vidx_t  same_on, same_off, free_v, old_v, pick;
    age_t   old_age, sel_age;
    r = '0;
    want_pitch = {1'b0, ev.pitch};
    if (int'(ev.track) >= NVOICES) return r;
    // ungrouped track: direct mapping bypasses the mask and leaves age alone
    if (ev.group == '0) begin
      if (!ev.direct) return r;
      if (ev.op == OP_NOTE_ON) begin
        voice_on[ev.track]    = 1'b1;
        model_pitch[ev.track] = want_pitch;
      end else begin
        voice_on[ev.track] = 1'b0;
      end
      r.voice = ev.track;
      r.found = 1'b1;
      return r;
    end
    cand = ev.group & alloc_mask;
    if (ev.op == OP_NOTE_OFF) begin
      for (int v = 0; v < NVOICES; v++) begin
        if (cand[v] && voice_on[v] && model_pitch[v] == want_pitch) begin
          voice_on[v] = 1'b0;
          r.voice = vidx_t'(v);
          r.found = 1'b1;
          return r;
        end
      end
      return r;
    end
    has_same_on = 1'b0; has_same_off = 1'b0; has_free = 1'b0; has_old = 1'b0;
    same_on = '0; same_off = '0; free_v = '0; old_v = '0; old_age = '0;
    for (int v = 0; v < NVOICES; v++) begin
      if (cand[v]) begin
        if (voice_on[v]) begin
          if (model_pitch[v] == want_pitch) begin
            same_on = vidx_t'(v);
            has_same_on = 1'b1;
          end
          if (!has_old || voice_age[v] > old_age) begin
            old_v = vidx_t'(v);
            old_age = voice_age[v];
            has_old = 1'b1;
          end
        end else begin
          if (model_pitch[v] == want_pitch) begin
            same_off = vidx_t'(v);
            has_same_off = 1'b1;
          end
          free_v = vidx_t'(v);
          has_free = 1'b1;
        end
      end
    end
    if (has_same_on) pick = same_on;
    else if (has_same_off) pick = same_off;
    else if (has_free) pick = free_v;
    else if (has_old) pick = old_v;
    else return r;
    sel_age = voice_age[pick];
    for (int v = 0; v < NVOICES; v++) begin
      if (cand[v] && vidx_t'(v) != pick && voice_age[v] <= sel_age)
        voice_age[v] = voice_age[v] + age_t'(1);
    end
    voice_age[pick]   = '0;
    model_pitch[pick] = want_pitch;
    voice_on[pick]    = 1'b1;
    r.voice = pick;
    r.found = 1'b1;
    return r;
  endfunction

  // mostly note-ons with released pitches coming back as matching note-offs
  function automatic note_event_t random_event();
    note_event_t ev;
    int idx, w, lo;
    ev.op     = ($urandom_range(99) < 55) ? OP_NOTE_ON : OP_NOTE_OFF;
    ev.pitch  = ($urandom_range(9) < 7) ? pitch_pool[$urandom_range(7)] : pitch_t'($urandom);
    ev.track  = vidx_t'($urandom);
    ev.direct = logic'($urandom_range(1));
    w  = $urandom_range(1, 6);
    lo = $urandom_range(15);
    case ($urandom_range(9))
      0:       ev.group = '0;
      1, 2:    ev.group = '1;
      3, 4:    ev.group = vmask_t'(((32'd1 << w) - 32'd1) << lo);
      5:       ev.group = vmask_t'(32'd1 << lo);
      default: ev.group = vmask_t'($urandom);
    endcase
    if (ev.op == OP_NOTE_OFF && held_notes.size() != 0 && $urandom_range(9) < 8) begin
      idx = $urandom_range(held_notes.size() - 1);
      ev = held_notes[idx];
      ev.op = OP_NOTE_OFF;
      held_notes.delete(idx);
    end else if (ev.op == OP_NOTE_ON) begin
      held_notes.push_back(ev);
      if (held_notes.size() > 24) void'(held_notes.pop_front());
    end
    return ev;
  endfunction

  task automatic push_event(logic op, pitch_t p, vidx_t t, vmask_t g, logic d);
    note_event_t ev;
    ev = '{op: op, pitch: p, track: t, group: g, direct: d};
    pending_events.push_back(ev);
  endtask

  task automatic write_mask(vmask_t m);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= m;
    alloc_mask = m;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, int want, int got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  // driver: predicts each transfer, then presents the next event or idles
  always @(posedge clk) begin : drive
    note_event_t nxt;
    logic take;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(allocate_voice(on_bus));
      if (!in_valid || !in_stall) begin
        take = pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct;
        if (take) begin
          nxt = pending_events.pop_front();
          on_bus <= nxt;
        end
        in_valid <= take;
      end
    end
  end

  // monitor: checks each result transfer against the oldest prediction
  always @(posedge clk) begin : watch
    voice_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, voice", -1, voice);
        end else begin
          want = expected_results.pop_front();
          if (found !== want.found) report_mismatch("found", want.found, found);
          if (voice !== want.voice) report_mismatch("voice", want.voice, voice);
        end
      end
      out_stall <= $urandom_range(99) < recv_stall_pct;
    end
  end

  initial begin : stimulus
    vmask_t masks[6];
    reset_voices();
    foreach (pitch_pool[i]) pitch_pool[i] = pitch_t'($urandom);
    pitch_pool[0] = '0;
    pitch_pool[7] = '1;
    masks = '{16'hFFFF, 16'h0000, vmask_t'($urandom), 16'h8001, vmask_t'($urandom), 16'hFFFF};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct  = 12;
    recv_stall_pct = 68;

    // fresh voices, full mask
    push_event(OP_NOTE_ON,  7'd0,   4'd0,  16'hFFFF, 1'b0);
    push_event(OP_NOTE_ON,  7'd127, 4'd1,  16'hFFFF, 1'b0);
    push_event(OP_NOTE_ON,  7'd127, 4'd1,  16'hFFFF, 1'b0);
    push_event(OP_NOTE_OFF, 7'd127, 4'd1,  16'hFFFF, 1'b0);
    push_event(OP_NOTE_ON,  7'd127, 4'd1,  16'hFFFF, 1'b1);
    push_event(OP_NOTE_OFF, 7'd1,   4'd1,  16'hFFFF, 1'b0);
    // ungrouped tracks, with and without direct mapping
    push_event(OP_NOTE_ON,  7'd5,   4'd0,  16'h0000, 1'b1);
    push_event(OP_NOTE_OFF, 7'd5,   4'd0,  16'h0000, 1'b1);
    push_event(OP_NOTE_ON,  7'd9,   4'd15, 16'h0000, 1'b0);
    push_event(OP_NOTE_ON,  7'd9,   4'd15, 16'h0000, 1'b1);
    // small group filled, then oldest voices stolen
    for (int i = 0; i < 6; i++)
      push_event(OP_NOTE_ON, pitch_t'(20 + i), 4'd3, 16'h000F, 1'b0);
    push_event(OP_NOTE_OFF, 7'd23,  4'd3,  16'h000F, 1'b0);
    push_event(OP_NOTE_ON,  7'd30,  4'd3,  16'h000F, 1'b0);
    // release outside and inside the group
    push_event(OP_NOTE_OFF, 7'd0,   4'd7,  16'h7FFF, 1'b0);
    push_event(OP_NOTE_OFF, 7'd0,   4'd7,  16'h8000, 1'b0);
    push_event(OP_NOTE_ON,  7'd60,  4'd8,  16'h5555, 1'b1);
    push_event(OP_NOTE_ON,  7'd61,  4'd9,  16'hAAAA, 1'b0);
    wait_idle();

    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        send_idle_pct  = 68;
        recv_stall_pct = 12;
      end else if (seg == 4) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      write_mask(masks[seg]);
      repeat (SEG_EVENTS) pending_events.push_back(random_event());
      wait_idle();
    end

    repeat (2 * PIPE_DEPTH + 4) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule
